// ----- sv/life_grid_generation_engine_core_macros.svh -----
// assertion macros shared by the life grid engine rtl
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define LGGE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define LGGE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lgge_pkg.sv -----
// shared types and constants of the life grid engine
`default_nettype none

package lgge_pkg;

   // field widths of the request and response beats
   localparam int OP_W       = 2;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 6;
   localparam int CLASS_W    = 2;

   // control and status register port
   localparam int COLS_REG_W = 8;
   localparam int ROWS_REG_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0]  CSR_COLS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_ROWS   = 1'b1;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd128;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd64;

   // smallest grid edge in use
   localparam int MIN_DIM = 3;

   // b3/s23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // bit positions inside one stored cell
   localparam int CUR_BIT  = 0;
   localparam int PREV_BIT = 1;

   // display classes
   localparam logic [CLASS_W-1:0] CLASS_DEAD     = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_BORN     = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_SURVIVED = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_DIED     = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SWEEP,
      ST_DELIVER
   } state_type;

   // one bit fed into the cell chain
   typedef struct packed {
      logic shift;
      logic data;
   } feed_type;

   // what the chain hands back for the cell at the window center
   typedef struct packed {
      logic center;
      logic next_alive;
   } cell_out_type;

endpackage

`default_nettype wire

// ----- sv/lgge_channels.sv -----
// request and response channel interfaces of the life grid engine
`default_nettype none

interface lgge_req_if;
   import lgge_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [COL_W-1:0]   col;
   logic [ROW_W-1:0]   row;
   logic               alive;

   modport source (output valid, output operation, output col, output row,
                   output alive, input ready);
   modport sink   (input valid, input operation, input col, input row,
                   input alive, output ready);
endinterface

interface lgge_rsp_if;
   import lgge_pkg::*;

   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] cell_class;
   logic               step_done;

   modport source (output valid, output cell_class, output step_done, input ready);
   modport sink   (input valid, input cell_class, input step_done, output ready);
endinterface

`default_nettype wire

// ----- sv/lgge_ram.sv -----
// generic single write port ram with one registered read port
`default_nettype none

module lgge_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 8192,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/lgge_cell_chain.sv -----
// chain of one-bit cells holding two grid lines plus three cells, with the b3/s23 rule
`default_nettype none

module lgge_cell_chain #(
   parameter int LINE_LEN = 130
) (
   input  logic                  clock,
   input  lgge_pkg::feed_type    feed,
   output lgge_pkg::cell_out_type tap
);
   import lgge_pkg::*;

   localparam int CHAIN_LEN = 2 * LINE_LEN + 3;

   // bit 0 is the newest cell; each cell hands its bit on to the next one
   logic [CHAIN_LEN-1:0] sr_ff;
   logic [CHAIN_LEN-1:0] sr_in;
   logic [3:0]           count;

   assign sr_in = {sr_ff[CHAIN_LEN-2:0], feed.data};

   always_ff @(posedge clock) begin
      if (feed.shift) begin
         sr_ff <= sr_in;
      end
   end

   // line below, own line and line above of the center tap
   assign count = 4'(sr_ff[0]) + 4'(sr_ff[1]) + 4'(sr_ff[2])
                + 4'(sr_ff[LINE_LEN]) + 4'(sr_ff[LINE_LEN + 2])
                + 4'(sr_ff[2 * LINE_LEN]) + 4'(sr_ff[2 * LINE_LEN + 1])
                + 4'(sr_ff[2 * LINE_LEN + 2]);

   assign tap.center     = sr_ff[LINE_LEN + 1];
   assign tap.next_alive = (count == BIRTH_COUNT)
                        || (sr_ff[LINE_LEN + 1] && (count == SURVIVE_COUNT));

endmodule

`default_nettype wire

// ----- sv/life_grid_generation_engine_core.sv -----
// life grid engine top level: b3/s23 on a wrapped grid with write, read and step beats
// write, read and unused beats pass the access and deliver states, then ready returns in idle
// step: the sweep feeds every line slot into the cell chain, one cell per cycle
// step time is set by the single ram read port feeding the cell chain one bit per cycle
// after reset a clearing pass zeroes every address of the store
// requests wait during the clearing pass; register writes are taken at any time
`default_nettype none
`include "life_grid_generation_engine_core_macros.svh"

module life_grid_generation_engine_core #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   lgge_req_if.sink                        req_chan,
   lgge_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [lgge_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lgge_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lgge_pkg::*;

   // line of the chain: wrap cell, the columns of the grid, wrap cell
   localparam int LINE_LEN = MAX_COLS + 2;
   localparam int CB       = $clog2(MAX_COLS);
   localparam int RB       = $clog2(MAX_ROWS);
   localparam int AW       = CB + RB;
   localparam int DEPTH    = 2 ** AW;
   localparam int NCW      = $clog2(MAX_COLS + 1);
   localparam int NRW      = $clog2(MAX_ROWS + 1);
   localparam int PW       = $clog2(LINE_LEN);
   localparam int SW       = $clog2(MAX_ROWS + 2);

   // ------------------------------------------------------------------
   // control registers and effective grid size
   // ------------------------------------------------------------------
   logic [COLS_REG_W-1:0] cols_ff;
   logic [ROWS_REG_W-1:0] rows_ff;
   logic [NCW-1:0]        nc;
   logic [NRW-1:0]        nr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata;
            CSR_ROWS: rows_ff <= csr_wdata[ROWS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // registers saturate to the range the store can hold
   always_comb begin
      if (32'(cols_ff) < MIN_DIM) begin
         nc = NCW'(MIN_DIM);
      end else if (32'(cols_ff) > MAX_COLS) begin
         nc = NCW'(MAX_COLS);
      end else begin
         nc = NCW'(cols_ff);
      end
      if (32'(rows_ff) < MIN_DIM) begin
         nr = NRW'(MIN_DIM);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         nr = NRW'(MAX_ROWS);
      end else begin
         nr = NRW'(rows_ff);
      end
   end

   // ------------------------------------------------------------------
   // state
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [AW-1:0]      clr_ff;
   op_type             op_ff;
   logic               hit_ff;
   logic               alive_ff;
   logic [AW-1:0]      op_addr_ff;

   logic               rsp_valid_ff;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic               rsp_done_ff;
   logic [CLASS_W-1:0] res_class_ff, res_class_in;
   logic               res_done_ff, res_done_in;
   logic               res_load;
   logic               out_load;
   logic               feed_start;

   // sweep pipeline: a issues the ram read, b shifts into the chain, c writes back
   logic               feed_on_ff;
   logic [SW-1:0]      fs_ff;
   logic [PW-1:0]      fp_ff;
   logic               b_valid_ff;
   logic [SW-1:0]      bs_ff;
   logic [PW-1:0]      bp_ff;
   logic               b_pad_ff;
   logic               b_wrap_ff;
   logic               c_valid_ff;
   logic [SW-1:0]      cs_ff;
   logic [PW-1:0]      cp_ff;

   logic               req_fire;
   logic               req_hit;
   logic [AW-1:0]      req_addr;

   logic [RB-1:0]      feed_row;
   logic [CB-1:0]      feed_col;
   logic               feed_pad;
   logic               feed_wrap;
   logic               feed_last;

   logic               center_ok;
   logic [AW-1:0]      center_addr;
   logic               sweep_end;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [1:0]         ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [1:0]         ram_rdata;

   feed_type           feed;
   cell_out_type       tap;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_hit        = (32'(req_chan.col) < 32'(nc)) && (32'(req_chan.row) < 32'(nr));
   assign req_addr       = {RB'(req_chan.row), CB'(req_chan.col)};

   // ------------------------------------------------------------------
   // feed order: line slot 0 is the last grid row, slots 1..rows the grid,
   // the final slot row 0 again; within a slot the last column leads,
   // the columns follow, column 0 closes, the rest is zero padding
   // ------------------------------------------------------------------
   always_comb begin
      if (fs_ff == '0) begin
         feed_row = RB'(32'(nr) - 1);
      end else if (32'(fs_ff) == 32'(nr) + 1) begin
         feed_row = '0;
      end else begin
         feed_row = RB'(32'(fs_ff) - 1);
      end
      if (fp_ff == '0) begin
         feed_col = CB'(32'(nc) - 1);
      end else if (32'(fp_ff) <= 32'(nc)) begin
         feed_col = CB'(32'(fp_ff) - 1);
      end else begin
         feed_col = '0;
      end
   end

   assign feed_pad  = 32'(fp_ff) > 32'(nc) + 1;
   // row 0 is already rewritten by then, so its old value sits in the previous bit
   assign feed_wrap = 32'(fs_ff) == 32'(nr) + 1;
   assign feed_last = feed_wrap && (32'(fp_ff) == 32'(nc) + 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_on_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (feed_start) begin
            feed_on_ff <= 1'b1;
         end else if (feed_on_ff && feed_last) begin
            feed_on_ff <= 1'b0;
         end
         b_valid_ff <= feed_on_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (feed_start) begin
         fs_ff <= '0;
         fp_ff <= '0;
      end else if (feed_on_ff) begin
         if (fp_ff == PW'(LINE_LEN - 1)) begin
            fp_ff <= '0;
            fs_ff <= fs_ff + 1'b1;
         end else begin
            fp_ff <= fp_ff + 1'b1;
         end
      end
      bs_ff     <= fs_ff;
      bp_ff     <= fp_ff;
      b_pad_ff  <= feed_pad;
      b_wrap_ff <= feed_wrap;
      cs_ff     <= bs_ff;
      cp_ff     <= bp_ff;
   end

   assign feed.shift = b_valid_ff;
   assign feed.data  = b_pad_ff ? 1'b0
                     : (b_wrap_ff ? ram_rdata[PREV_BIT] : ram_rdata[CUR_BIT]);

   lgge_cell_chain #(
      .LINE_LEN (LINE_LEN)
   ) u_chain (
      .clock (clock),
      .feed  (feed),
      .tap   (tap)
   );

   // the window center trails the newest chain cell by one line and one cell
   assign center_ok = c_valid_ff
                   && (32'(cs_ff) >= 2) && (32'(cs_ff) <= 32'(nr) + 1)
                   && (32'(cp_ff) >= 2) && (32'(cp_ff) <= 32'(nc) + 1);
   assign center_addr = {RB'(32'(cs_ff) - 2), CB'(32'(cp_ff) - 2)};
   assign sweep_end   = c_valid_ff && (32'(cs_ff) == 32'(nr) + 1)
                     && (32'(cp_ff) == 32'(nc) + 1);

   // ------------------------------------------------------------------
   // cell store
   // ------------------------------------------------------------------
   assign ram_raddr = feed_on_ff ? {feed_row, feed_col} : req_addr;

   lgge_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   function automatic logic [CLASS_W-1:0] class_of(input logic [1:0] v);
      logic [CLASS_W-1:0] c;
      case ({v[PREV_BIT], v[CUR_BIT]})
         2'b01:   c = CLASS_BORN;
         2'b11:   c = CLASS_SURVIVED;
         2'b10:   c = CLASS_DIED;
         default: c = CLASS_DEAD;
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ram_we       = 1'b0;
      ram_waddr    = op_addr_ff;
      ram_wdata    = {ram_rdata[PREV_BIT], alive_ff};
      feed_start   = 1'b0;
      res_load     = 1'b0;
      res_class_in = CLASS_DEAD;
      res_done_in  = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.operation == OP_STEP) begin
                  feed_start = 1'b1;
                  state_in   = ST_SWEEP;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            // read data of the beat's cell is here; writes keep the previous bit
            res_load = 1'b1;
            if (op_ff == OP_READ && hit_ff) begin
               res_class_in = class_of(ram_rdata);
            end
            if (op_ff == OP_WRITE && hit_ff) begin
               ram_we = 1'b1;
            end
            state_in = ST_DELIVER;
         end
         ST_SWEEP: begin
            ram_we    = center_ok;
            ram_waddr = center_addr;
            ram_wdata = {tap.center, tap.next_alive};
            if (sweep_end) begin
               res_load    = 1'b1;
               res_done_in = 1'b1;
               state_in    = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // captured request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= op_type'(req_chan.operation);
         hit_ff     <= req_hit;
         alive_ff   <= req_chan.alive;
         op_addr_ff <= req_addr;
      end
      if (res_load) begin
         res_class_ff <= res_class_in;
         res_done_ff  <= res_done_in;
      end
   end

   // response register, parted from the sequencer so a result can wait
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_class_ff <= res_class_ff;
         rsp_done_ff  <= res_done_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_class = rsp_class_ff;
   assign rsp_chan.step_done  = rsp_done_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `LGGE_ASSERT_NOW(a_idle_pipe_empty, req_chan.ready, !feed_on_ff && !b_valid_ff && !c_valid_ff, "request taken while sweep pipeline busy")
   `LGGE_ASSERT_NOW(a_sweep_write_in_grid, state_ff == ST_SWEEP && ram_we, 32'(center_addr[AW-1:CB]) < 32'(nr), "sweep write outside rows in use")
   `LGGE_ASSERT_NOW(a_done_is_dead, rsp_chan.valid && rsp_chan.step_done, rsp_chan.cell_class == CLASS_DEAD, "step result carries a cell class")
   `LGGE_ASSERT_NEXT(a_deliver_shows, state_ff == ST_DELIVER && (!rsp_valid_ff || rsp_chan.ready), rsp_chan.valid && state_ff == ST_IDLE, "result not presented after delivery")

endmodule

`default_nettype wire

// ----- tb/sv/life_grid_generation_engine_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the life grid engine: cell grid scoreboard, random beats and stalls

module life_grid_generation_engine_core_tb;
   import lgge_pkg::*;

   localparam int GRID_COLS = 128;
   localparam int GRID_ROWS = 64;

   // longest quiet stretch: clearing pass or a full-grid step plus a long receiver hold
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int ITEM_TARGET    = 90;
   localparam int LONG_HOLD      = 250;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [CLASS_W-1:0] cell_class;
      logic               step_done;
   } cell_reply_type;

   // mirror of the cell store and grid size, predicts one reply per request beat
   class generation_scoreboard_type;
      logic [1:0]            cells [GRID_ROWS][GRID_COLS];
      logic [COLS_REG_W-1:0] cols_reg;
      logic [ROWS_REG_W-1:0] rows_reg;
      cell_reply_type        expected_replies [$];
      int                    failures;

      function new();
         foreach (cells[r, c]) cells[r][c] = 2'b00;
         cols_reg = COLS_RESET;
         rows_reg = ROWS_RESET;
         failures = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_COLS) cols_reg = data[COLS_REG_W-1:0];
         else if (idx == CSR_ROWS) rows_reg = data[ROWS_REG_W-1:0];
      endfunction

      function int cols_span();
         if (cols_reg < MIN_DIM) return MIN_DIM;
         if (cols_reg > GRID_COLS) return GRID_COLS;
         return int'(cols_reg);
      endfunction

      function int rows_span();
         if (rows_reg < MIN_DIM) return MIN_DIM;
         if (rows_reg > GRID_ROWS) return GRID_ROWS;
         return int'(rows_reg);
      endfunction

      // cell bits are {prev, cur}
      function logic [CLASS_W-1:0] display_class(logic [1:0] bits);
         case (bits)
            2'b01:   return CLASS_BORN;
            2'b11:   return CLASS_SURVIVED;
            2'b10:   return CLASS_DIED;
            default: return CLASS_DEAD;
         endcase
      endfunction

      function void advance_generation(int nc, int nr);
         logic was_alive [GRID_ROWS][GRID_COLS];
         int   neighbors;
         for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
               was_alive[r][c] = cells[r][c][CUR_BIT];
         for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
               neighbors = 0;
               for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++)
                     if (dr != 0 || dc != 0)
                        neighbors += was_alive[(r + dr + nr) % nr][(c + dc + nc) % nc];
               cells[r][c][PREV_BIT] = was_alive[r][c];
               cells[r][c][CUR_BIT]  = (neighbors == BIRTH_COUNT) ||
                                       (was_alive[r][c] && neighbors == SURVIVE_COUNT);
            end
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [COL_W-1:0] col,
                                 logic [ROW_W-1:0] row, logic alive);
         cell_reply_type reply;
         int             nc;
         int             nr;
         nc = cols_span();
         nr = rows_span();
         reply.cell_class = CLASS_DEAD;
         reply.step_done  = 1'b0;
         case (op)
            OP_WRITE: if (col < nc && row < nr) cells[row][col][CUR_BIT] = alive;
            OP_READ:  if (col < nc && row < nr) reply.cell_class = display_class(cells[row][col]);
            OP_STEP: begin
               advance_generation(nc, nr);
               reply.step_done = 1'b1;
            end
            default: ;
         endcase
         expected_replies.push_back(reply);
      endfunction

      function void check_response(logic [CLASS_W-1:0] cell_class, logic step_done);
         cell_reply_type want;
         if (expected_replies.size() == 0) begin
            $error("response beat with none expected: cell_class %0d step_done %0d",
                   cell_class, step_done);
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         if (cell_class !== want.cell_class) begin
            $error("cell_class: expected %0d actual %0d", want.cell_class, cell_class);
            failures++;
         end
         if (step_done !== want.step_done) begin
            $error("step_done: expected %0d actual %0d", want.step_done, step_done);
            failures++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_COLS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lgge_req_if req_chan ();
   lgge_rsp_if rsp_chan ();

   generation_scoreboard_type board;

   // sender burst state
   int burst_left = 0;
   int beats_sent = 0;

   // receiver stall state
   int         replies_seen  = 0;
   int         hold_left     = 0;
   int         pattern_left  = 0;
   logic [7:0] stall_pattern = 8'hFF;

   int idle_cycles = 0;

   life_grid_generation_engine_core #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // offer one request beat, with a random gap between bursts, and note it once taken
   task automatic offer_request(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
                                input logic [ROW_W-1:0] row, input logic alive);
      int gap;
      if (burst_left == 0) begin
         // some bursts follow back to back so long runs go by with no gap
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.col       <= col;
      req_chan.row       <= row;
      req_chan.alive     <= alive;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      board.note_request(op, col, row, alive);
      beats_sent++;
   endtask

   // registers change only with nothing in flight: drop valid and let every reply come back
   task automatic configure_grid(input logic [CSR_DATA_W-1:0] cols_val,
                                 input logic [CSR_DATA_W-1:0] rows_val);
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_COLS;
      csr_wdata <= cols_val;
      @(posedge clock);
      board.set_register(CSR_COLS, cols_val);
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_val;
      @(posedge clock);
      board.set_register(CSR_ROWS, rows_val);
      csr_we <= 1'b0;
   endtask

   // any operation, any coordinate, often outside the grid in use
   task automatic offer_noise_beat();
      logic [OP_W-1:0]  op;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             alive;
      op    = OP_W'($urandom_range(0, 3));
      col   = COL_W'($urandom_range(0, 127));
      row   = ROW_W'($urandom_range(0, 63));
      alive = 1'($urandom_range(0, 1));
      offer_request(op, col, row, alive);
   endtask

   // a write or read inside the grid in use, now and then a fully random beat instead
   task automatic offer_cell_beat(input logic [OP_W-1:0] op, input int nc, input int nr);
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             alive;
      if ($urandom_range(0, 5) == 0) begin
         offer_noise_beat();
      end else begin
         col   = COL_W'($urandom_range(0, nc - 1));
         row   = ROW_W'($urandom_range(0, nr - 1));
         alive = (op == OP_WRITE) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
         offer_request(op, col, row, alive);
      end
   endtask

   task automatic run_directed();
      // three corners that touch each other only through both wraps
      offer_request(OP_WRITE, 7'd0, 6'd0, 1'b1);
      offer_request(OP_WRITE, 7'd127, 6'd0, 1'b1);
      offer_request(OP_WRITE, 7'd127, 6'd63, 1'b1);
      // lone cell, starves on the next step
      offer_request(OP_WRITE, 7'd64, 6'd32, 1'b1);
      // set then cleared again before any step
      offer_request(OP_WRITE, 7'd5, 6'd7, 1'b1);
      offer_request(OP_WRITE, 7'd5, 6'd7, 1'b0);
      offer_request(OP_READ, 7'd0, 6'd0, 1'b0);
      offer_request(OP_READ, 7'd5, 6'd7, 1'b1);
      // unused code with every field bit set: no change, all-zero reply
      offer_request(OP_UNUSED, 7'd127, 6'd63, 1'b1);
      offer_request(OP_STEP, 7'd0, 6'd0, 1'b0);
      // birth from the three corners, survivors, a death
      offer_request(OP_READ, 7'd0, 6'd63, 1'b0);
      offer_request(OP_READ, 7'd127, 6'd63, 1'b0);
      offer_request(OP_READ, 7'd64, 6'd32, 1'b0);
      // killed by a write rather than by the rule
      offer_request(OP_WRITE, 7'd0, 6'd0, 1'b0);
      offer_request(OP_READ, 7'd0, 6'd0, 1'b0);

      // zero in both registers saturates to the smallest grid
      configure_grid(8'd0, 8'd0);
      offer_request(OP_READ, 7'd127, 6'd63, 1'b0);
      offer_request(OP_WRITE, 7'd127, 6'd0, 1'b0);
      offer_request(OP_WRITE, 7'd1, 6'd1, 1'b1);
      offer_request(OP_STEP, 7'd127, 6'd63, 1'b1);
      offer_request(OP_READ, 7'd1, 6'd1, 1'b0);

      // all ones saturates back to the full grid, cells beyond the small grid kept their bits
      configure_grid(8'd255, 8'd255);
      offer_request(OP_READ, 7'd127, 6'd63, 1'b0);
      offer_request(OP_READ, 7'd127, 6'd0, 1'b0);
      offer_request(OP_READ, 7'd0, 6'd63, 1'b0);
   endtask

   // one setting: seed a pattern, step a few generations, read cells after each
   task automatic run_random_phase();
      logic [CSR_DATA_W-1:0] cols_val;
      logic [CSR_DATA_W-1:0] rows_val;
      bit                    wide;
      int                    nc;
      int                    nr;
      int                    steps;
      // full-range settings are rare since a step over a tall grid is slow
      wide = ($urandom_range(0, 5) == 0);
      if (wide) begin
         cols_val = CSR_DATA_W'($urandom_range(0, 255));
         rows_val = CSR_DATA_W'($urandom_range(0, 255));
      end else begin
         cols_val = CSR_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 12));
         rows_val = CSR_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 8));
      end
      configure_grid(cols_val, rows_val);
      nc = board.cols_span();
      nr = board.rows_span();
      repeat ($urandom_range(3, 12)) begin
         if ($urandom_range(0, 5) == 0) offer_noise_beat();
         else offer_cell_beat(OP_WRITE, nc, nr);
      end
      steps = wide ? 1 : $urandom_range(1, 3);
      repeat (steps) begin
         offer_request(OP_STEP, COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)));
         repeat ($urandom_range(3, 6)) begin
            if ($urandom_range(0, 5) == 0) offer_noise_beat();
            else offer_cell_beat(OP_READ, nc, nr);
         end
      end
   endtask

   // receiver: checks each response beat, stalls on a pattern, holds off long now and then
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         board.check_response(rsp_chan.cell_class, rsp_chan.step_done);
         replies_seen++;
         // long hold while the sender keeps offering, so the request side backs up
         if (replies_seen % 45 == 20) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            pattern_left  = 64;
         end
         pattern_left--;
         rsp_chan.ready <= stall_pattern[pattern_left % 8];
      end
   end

   // watchdog on cycles with no beat taken on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      board = new();
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_WRITE;
      req_chan.col       = '0;
      req_chan.row       = '0;
      req_chan.alive     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // requests sit through the clearing pass until the engine raises ready
      run_directed();
      while (beats_sent < ITEM_TARGET) run_random_phase();

      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      // once every reply is back, a short tail catches stray response beats
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
